// ----- design/ids_pkg.sv -----
// shared types, sizes and codes for the integer domain bitset store
package ids_pkg;

  localparam int DOMAIN_BITS = 1024;
  localparam int WORD_BITS   = 64;
  localparam int WORD_COUNT  = (DOMAIN_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int OFF_W       = $clog2(DOMAIN_BITS);
  localparam int CNT_W       = OFF_W + 1;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int IDX_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int RW          = OFF_W + 2;
  localparam int OW          = 34;
  localparam int RESET_SPAN  = (DOMAIN_BITS < 1024) ? DOMAIN_BITS : 1024;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic signed [RW-1:0]  rng_t;
  typedef logic [OFF_W-1:0]      off_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic signed [OW-1:0]  wide_t;

  // operation codes
  localparam logic [2:0] OP_REMOVE   = 3'd0;
  localparam logic [2:0] OP_CONTAINS = 3'd1;
  localparam logic [2:0] OP_NEXT     = 3'd2;
  localparam logic [2:0] OP_PREV     = 3'd3;
  localparam logic [2:0] OP_GAP      = 3'd4;
  localparam logic [2:0] OP_CRANGE   = 3'd5;
  localparam logic [2:0] OP_RELOAD   = 3'd6;

  // status codes
  localparam logic [2:0] STS_NOCHG   = 3'd0;
  localparam logic [2:0] STS_CHANGED = 3'd1;
  localparam logic [2:0] STS_CLEAR   = 3'd2;
  localparam logic [2:0] STS_INVALID = 3'd3;
  localparam logic [2:0] STS_QUERY   = 3'd4;

  // answer kinds
  localparam logic [1:0] KIND_FINITE = 2'd0;
  localparam logic [1:0] KIND_PINF   = 2'd1;
  localparam logic [1:0] KIND_MINF   = 2'd2;

  // ranges and modes for one sweep over the words
  typedef struct packed {
    rng_t a_lo;
    rng_t a_hi;
    rng_t f_lo;
    rng_t f_hi;
    rng_t l_lo;
    rng_t l_hi;
    logic clear_a;
    logic fill_a;
    logic invert_f;
  } scan_cfg_t;

  // what one sweep collected
  typedef struct packed {
    logic all_set;
    logic f_hit;
    off_t f_pos;
    logic l_hit;
    off_t l_pos;
    cnt_t removed;
  } scan_res_t;

  // reset contents of one word
  function automatic word_t reset_word(int idx);
    word_t w;
    w = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (idx * WORD_BITS + j < RESET_SPAN) w[j] = 1'b1;
    end
    return w;
  endfunction

endpackage

// ----- design/ids_cell.sv -----
// one storage cell of the word ring
module ids_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  ids_pkg::word_t    reset_value,
  input  ids_pkg::word_t    next_word,
  output ids_pkg::word_t    word
);

  // hold the word, take the neighbor's word on a shift
  always_ff @(posedge clk) begin
    if (rst) begin
      word <= reset_value;
    end else if (shift) begin
      word <= next_word;
    end
  end

endmodule

// ----- design/ids_head.sv -----
// head cell: masks, clears, fills and searches the word passing through
module ids_head (
  input  logic                 clk,
  input  logic                 clr,
  input  logic                 step,
  input  ids_pkg::idx_t        k,
  input  ids_pkg::word_t       word_in,
  input  ids_pkg::scan_cfg_t   cfg,
  output ids_pkg::word_t       word_out,
  output ids_pkg::scan_res_t   res
);

  function automatic ids_pkg::word_t range_mask(ids_pkg::rng_t lo, ids_pkg::rng_t hi,
                                                ids_pkg::rng_t base);
    ids_pkg::rng_t top_b;
    ids_pkg::rng_t dl;
    ids_pkg::rng_t dh;
    ids_pkg::word_t ones;
    ids_pkg::word_t ml;
    ids_pkg::word_t mh;
    top_b = base + ids_pkg::rng_t'(ids_pkg::WORD_BITS - 1);
    dl    = lo - base;
    dh    = hi - base;
    ones  = '1;
    if (lo <= base) ml = '1;
    else if (lo > top_b) ml = '0;
    else ml = ones << dl[ids_pkg::BIT_W-1:0];
    if (hi >= top_b) mh = '1;
    else if (hi < base) mh = '0;
    else mh = ones >> (ids_pkg::BIT_W'(ids_pkg::WORD_BITS - 1) - dh[ids_pkg::BIT_W-1:0]);
    return ml & mh;
  endfunction

  function automatic logic [ids_pkg::BIT_W-1:0] first_bit(ids_pkg::word_t v);
    logic [ids_pkg::BIT_W-1:0] r;
    r = '0;
    for (int i = ids_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = ids_pkg::BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [ids_pkg::BIT_W-1:0] last_bit(ids_pkg::word_t v);
    logic [ids_pkg::BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < ids_pkg::WORD_BITS; i++) begin
      if (v[i]) r = ids_pkg::BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [ids_pkg::BIT_W:0] popcount(ids_pkg::word_t v);
    logic [ids_pkg::BIT_W:0] s;
    s = '0;
    for (int i = 0; i < ids_pkg::WORD_BITS; i++) begin
      s = s + (ids_pkg::BIT_W+1)'(v[i]);
    end
    return s;
  endfunction

  ids_pkg::rng_t  base;
  ids_pkg::word_t ma;
  ids_pkg::word_t mf;
  ids_pkg::word_t ml;
  ids_pkg::word_t w_cl;
  ids_pkg::word_t sf;
  ids_pkg::word_t sl;

  // per word masks and the rewritten word
  always_comb begin
    base     = ids_pkg::rng_t'(int'(k) * ids_pkg::WORD_BITS);
    ma       = range_mask(cfg.a_lo, cfg.a_hi, base);
    mf       = range_mask(cfg.f_lo, cfg.f_hi, base);
    ml       = range_mask(cfg.l_lo, cfg.l_hi, base);
    w_cl     = cfg.clear_a ? (word_in & ~ma) : word_in;
    word_out = cfg.fill_a ? ma : w_cl;
    sf       = (cfg.invert_f ? ~word_in : w_cl) & mf;
    sl       = w_cl & ml;
  end

  // accumulate answers over the sweep
  always_ff @(posedge clk) begin
    if (clr) begin
      res.all_set <= 1'b1;
      res.f_hit   <= 1'b0;
      res.f_pos   <= '0;
      res.l_hit   <= 1'b0;
      res.l_pos   <= '0;
      res.removed <= '0;
    end else if (step) begin
      if ((~word_in & ma) != '0) res.all_set <= 1'b0;
      if (!res.f_hit && sf != '0) begin
        res.f_hit <= 1'b1;
        res.f_pos <= ids_pkg::off_t'(base + ids_pkg::rng_t'(first_bit(sf)));
      end
      if (sl != '0) begin
        res.l_hit <= 1'b1;
        res.l_pos <= ids_pkg::off_t'(base + ids_pkg::rng_t'(last_bit(sl)));
      end
      if (cfg.clear_a) begin
        res.removed <= res.removed + ids_pkg::cnt_t'(popcount(word_in & ma));
      end
    end
  end

endmodule

// ----- design/integer_domain_bitset_store.sv -----
// integer domain bitset store: a ring of word cells swept by one head cell
// flow: an accepted word passes setup, a sweep of all WORD_COUNT words and finish, then the result is registered
// a new word is taken only back in idle, after finish has loaded the result slot; out_stall holding the
//   previous result holds the finish state; the sweep rotates every cell past the head once, one word a cycle
// reset: full domain 0..1023 present, bounds 0 and 1023, count 1024, no clearing pass
module integer_domain_bitset_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 operation,
  input  logic signed [31:0]         value_a,
  input  logic signed [31:0]         value_b,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 status,
  output logic                       found,
  output logic signed [31:0]         answer_value,
  output logic [1:0]                 answer_kind,
  output logic signed [31:0]         domain_min,
  output logic signed [31:0]         domain_max,
  output logic [ids_pkg::CNT_W-1:0]  member_count,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam logic [3:0] RC_INVALID   = 4'd0;
  localparam logic [3:0] RC_CLEAR     = 4'd1;
  localparam logic [3:0] RC_NOCHG     = 4'd2;
  localparam logic [3:0] RC_REMOVE    = 4'd3;
  localparam logic [3:0] RC_CONTAINS  = 4'd4;
  localparam logic [3:0] RC_QUERY     = 4'd5;
  localparam logic [3:0] RC_NEXT_INF  = 4'd6;
  localparam logic [3:0] RC_NEXT_MIN  = 4'd7;
  localparam logic [3:0] RC_NEXT_SCAN = 4'd8;
  localparam logic [3:0] RC_PREV_INF  = 4'd9;
  localparam logic [3:0] RC_PREV_MAX  = 4'd10;
  localparam logic [3:0] RC_PREV_SCAN = 4'd11;
  localparam logic [3:0] RC_GAP       = 4'd12;
  localparam logic [3:0] RC_RELOAD    = 4'd13;

  localparam logic IDX_LOW  = 1'b0;
  localparam logic IDX_HIGH = 1'b1;

  localparam ids_pkg::idx_t LAST_K = ids_pkg::idx_t'(ids_pkg::WORD_COUNT - 1);

  function automatic ids_pkg::rng_t clamp(ids_pkg::wide_t x);
    if (x < ids_pkg::wide_t'(-1)) return ids_pkg::rng_t'(-1);
    else if (x > ids_pkg::wide_t'(ids_pkg::DOMAIN_BITS))
      return ids_pkg::rng_t'(ids_pkg::DOMAIN_BITS);
    else return ids_pkg::rng_t'(x);
  endfunction

  logic [1:0]          state;
  ids_pkg::idx_t       k;
  logic signed [31:0]  domain_low;
  logic signed [31:0]  domain_high;
  ids_pkg::off_t       lowest;
  ids_pkg::off_t       highest;
  ids_pkg::cnt_t       population;

  logic [2:0]          op_r;
  logic signed [31:0]  a_r;
  logic signed [31:0]  b_r;

  ids_pkg::scan_cfg_t  sc;
  ids_pkg::scan_cfg_t  sc_next;
  logic [3:0]          rc;
  logic [3:0]          rc_next;
  logic                upd_low;
  logic                upd_low_next;
  logic                upd_high;
  logic                upd_high_next;
  ids_pkg::cnt_t       span;
  ids_pkg::cnt_t       span_next;

  ids_pkg::scan_res_t  res;
  ids_pkg::word_t      cell_word [ids_pkg::WORD_COUNT];
  ids_pkg::word_t      head_word;
  logic                scan_en;
  logic                cfg_wr;

  ids_pkg::wide_t      low_w;
  ids_pkg::wide_t      hi_w;
  ids_pkg::wide_t      ao;
  ids_pkg::wide_t      bo;
  ids_pkg::wide_t      lw;
  ids_pkg::wide_t      hw;
  ids_pkg::wide_t      ca;
  ids_pkg::wide_t      cb;
  ids_pkg::wide_t      span_w;

  logic [2:0]          sts_next;
  logic                fnd_next;
  logic [31:0]         ans_next;
  logic [1:0]          kind_next;
  ids_pkg::off_t       lowest_next;
  ids_pkg::off_t       highest_next;
  ids_pkg::cnt_t       pop_next;

  assign in_stall = (state != ST_IDLE);
  assign scan_en  = (state == ST_SCAN);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == IDX_HIGH) ? domain_high : domain_low;

  // ring of word cells, the head feeds the last cell
  for (genvar i = 0; i < ids_pkg::WORD_COUNT; i++) begin : g_cell
    ids_pkg::word_t nxt;
    if (i == ids_pkg::WORD_COUNT - 1) begin : g_tail
      assign nxt = head_word;
    end else begin : g_mid
      assign nxt = cell_word[i+1];
    end
    ids_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift       (scan_en),
      .reset_value (ids_pkg::reset_word(i)),
      .next_word   (nxt),
      .word        (cell_word[i])
    );
  end

  ids_head u_head (
    .clk      (clk),
    .clr      (state == ST_SETUP),
    .step     (scan_en),
    .k        (k),
    .word_in  (cell_word[0]),
    .cfg      (sc),
    .word_out (head_word),
    .res      (res)
  );

  // decode the word into sweep ranges and a result class
  always_comb begin
    low_w  = ids_pkg::wide_t'(domain_low);
    hi_w   = ids_pkg::wide_t'(domain_high);
    ao     = ids_pkg::wide_t'(a_r) - low_w;
    bo     = ids_pkg::wide_t'(b_r) - low_w;
    lw     = ids_pkg::wide_t'(lowest);
    hw     = ids_pkg::wide_t'(highest);
    ca     = (ao < lw) ? lw : ao;
    cb     = (bo > hw) ? hw : bo;
    span_w = hi_w - low_w + ids_pkg::wide_t'(1);

    sc_next.a_lo     = ids_pkg::rng_t'(ids_pkg::DOMAIN_BITS);
    sc_next.a_hi     = ids_pkg::rng_t'(-1);
    sc_next.f_lo     = ids_pkg::rng_t'(ids_pkg::DOMAIN_BITS);
    sc_next.f_hi     = ids_pkg::rng_t'(-1);
    sc_next.l_lo     = ids_pkg::rng_t'(ids_pkg::DOMAIN_BITS);
    sc_next.l_hi     = ids_pkg::rng_t'(-1);
    sc_next.clear_a  = 1'b0;
    sc_next.fill_a   = 1'b0;
    sc_next.invert_f = 1'b0;
    rc_next          = RC_INVALID;
    upd_low_next     = 1'b0;
    upd_high_next    = 1'b0;
    span_next        = span;

    case (op_r)
      ids_pkg::OP_REMOVE: begin
        if (a_r > b_r) begin
          rc_next = RC_INVALID;
        end else if (ao <= lw && hw <= bo) begin
          rc_next = RC_CLEAR;
        end else if (bo < lw || hw < ao) begin
          rc_next = RC_NOCHG;
        end else begin
          rc_next         = RC_REMOVE;
          sc_next.a_lo    = clamp(ca);
          sc_next.a_hi    = clamp(cb);
          sc_next.clear_a = 1'b1;
          if (ca == lw) begin
            upd_low_next = 1'b1;
            sc_next.f_lo = clamp(cb + ids_pkg::wide_t'(1));
            sc_next.f_hi = clamp(hw);
          end else if (cb == hw) begin
            upd_high_next = 1'b1;
            sc_next.l_lo  = clamp(lw);
            sc_next.l_hi  = clamp(ca - ids_pkg::wide_t'(1));
          end
        end
      end
      ids_pkg::OP_CONTAINS: begin
        if (ao >= lw && ao <= hw) begin
          rc_next      = RC_CONTAINS;
          sc_next.a_lo = clamp(ao);
          sc_next.a_hi = clamp(ao);
        end else begin
          rc_next = RC_QUERY;
        end
      end
      ids_pkg::OP_NEXT: begin
        if (ao >= hw) begin
          rc_next = RC_NEXT_INF;
        end else if (ao < lw) begin
          rc_next = RC_NEXT_MIN;
        end else begin
          rc_next      = RC_NEXT_SCAN;
          sc_next.f_lo = clamp(ao + ids_pkg::wide_t'(1));
          sc_next.f_hi = clamp(hw);
        end
      end
      ids_pkg::OP_PREV: begin
        if (ao <= lw) begin
          rc_next = RC_PREV_INF;
        end else if (ao > hw) begin
          rc_next = RC_PREV_MAX;
        end else begin
          rc_next      = RC_PREV_SCAN;
          sc_next.l_lo = clamp(lw);
          sc_next.l_hi = clamp(ao - ids_pkg::wide_t'(1));
        end
      end
      ids_pkg::OP_GAP: begin
        rc_next          = RC_GAP;
        sc_next.f_lo     = clamp(((ao < lw) ? lw : ao) + ids_pkg::wide_t'(1));
        sc_next.f_hi     = clamp(hw);
        sc_next.invert_f = 1'b1;
      end
      ids_pkg::OP_CRANGE: begin
        if (a_r > b_r) begin
          rc_next = RC_INVALID;
        end else if (ao >= lw && bo <= hw) begin
          rc_next      = RC_CONTAINS;
          sc_next.a_lo = clamp(ao);
          sc_next.a_hi = clamp(bo);
        end else begin
          rc_next = RC_QUERY;
        end
      end
      ids_pkg::OP_RELOAD: begin
        if (low_w > hi_w || span_w > ids_pkg::wide_t'(ids_pkg::DOMAIN_BITS)) begin
          rc_next = RC_INVALID;
        end else begin
          rc_next        = RC_RELOAD;
          sc_next.a_lo   = ids_pkg::rng_t'(0);
          sc_next.a_hi   = clamp(span_w - ids_pkg::wide_t'(1));
          sc_next.fill_a = 1'b1;
          span_next      = ids_pkg::cnt_t'(span_w);
        end
      end
      default: begin
        rc_next = RC_INVALID;
      end
    endcase
  end

  // build the result word and the new bounds after the sweep
  always_comb begin
    sts_next     = ids_pkg::STS_QUERY;
    fnd_next     = 1'b0;
    ans_next     = '0;
    kind_next    = ids_pkg::KIND_FINITE;
    lowest_next  = lowest;
    highest_next = highest;
    pop_next     = population;
    case (rc)
      RC_INVALID: sts_next = ids_pkg::STS_INVALID;
      RC_CLEAR:   sts_next = ids_pkg::STS_CLEAR;
      RC_NOCHG:   sts_next = ids_pkg::STS_NOCHG;
      RC_REMOVE: begin
        sts_next = ids_pkg::STS_CHANGED;
        pop_next = population - res.removed;
        if (upd_low) lowest_next = res.f_pos;
        if (upd_high) highest_next = res.l_pos;
      end
      RC_CONTAINS: fnd_next = res.all_set;
      RC_QUERY:    sts_next = ids_pkg::STS_QUERY;
      RC_NEXT_INF: kind_next = ids_pkg::KIND_PINF;
      RC_NEXT_MIN: ans_next = domain_low + 32'(lowest);
      RC_NEXT_SCAN: begin
        if (res.f_hit) ans_next = domain_low + 32'(res.f_pos);
        else kind_next = ids_pkg::KIND_PINF;
      end
      RC_PREV_INF: kind_next = ids_pkg::KIND_MINF;
      RC_PREV_MAX: ans_next = domain_low + 32'(highest);
      RC_PREV_SCAN: begin
        if (res.l_hit) ans_next = domain_low + 32'(res.l_pos);
        else kind_next = ids_pkg::KIND_MINF;
      end
      RC_GAP: begin
        if (res.f_hit) begin
          ans_next = domain_low + 32'(res.f_pos);
          fnd_next = 1'b1;
        end else begin
          kind_next = ids_pkg::KIND_PINF;
        end
      end
      RC_RELOAD: begin
        sts_next     = ids_pkg::STS_CHANGED;
        lowest_next  = '0;
        highest_next = ids_pkg::off_t'(span - ids_pkg::cnt_t'(1));
        pop_next     = span;
      end
      default: sts_next = ids_pkg::STS_INVALID;
    endcase
  end

  // control, configuration and domain bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      k           <= '0;
      out_valid   <= 1'b0;
      domain_low  <= 32'sd0;
      domain_high <= 32'sd1023;
      lowest      <= '0;
      highest     <= ids_pkg::off_t'(ids_pkg::RESET_SPAN - 1);
      population  <= ids_pkg::cnt_t'(ids_pkg::RESET_SPAN);
    end else begin
      // result slot: load on finish, free when taken
      if (state == ST_FIN && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2] == IDX_LOW) domain_low <= pwdata;
        else domain_high <= pwdata;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_SETUP;
        end
        ST_SETUP: begin
          k     <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          k <= k + ids_pkg::idx_t'(1);
          if (k == LAST_K) state <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            lowest     <= lowest_next;
            highest    <= highest_next;
            population <= pop_next;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_r <= operation;
      a_r  <= value_a;
      b_r  <= value_b;
    end
    if (state == ST_SETUP) begin
      sc       <= sc_next;
      rc       <= rc_next;
      upd_low  <= upd_low_next;
      upd_high <= upd_high_next;
      span     <= span_next;
    end
    if (state == ST_FIN && (!out_valid || !out_stall)) begin
      status       <= sts_next;
      found        <= fnd_next;
      answer_value <= ans_next;
      answer_kind  <= kind_next;
      domain_min   <= domain_low + 32'(lowest_next);
      domain_max   <= domain_low + 32'(highest_next);
      member_count <= pop_next;
    end
  end

  // checks
  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    lowest <= highest) else $error("lowest offset above highest offset");

  a_scan_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && k != LAST_K) |=> (state == ST_SCAN))
    else $error("sweep left before the last word");

  a_accept_setup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_SETUP))
    else $error("accepted word did not start setup");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (member_count != '0 &&
                   member_count <= ids_pkg::cnt_t'(ids_pkg::DOMAIN_BITS)))
    else $error("member count out of range");

endmodule

// ----- test/integer_domain_bitset_store_test.sv -----
// testbench for the integer domain bitset store: directed, per-setting and random words
module integer_domain_bitset_store_test;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [2:0] REG_LOW   = 3'd0;
  localparam logic [2:0] REG_HIGH  = 3'd4;
  localparam int         STALL_LIMIT = 3000;

  typedef struct {
    logic [2:0]  status;
    logic        found;
    logic [31:0] answer_value;
    logic [1:0]  answer_kind;
    logic [31:0] domain_min;
    logic [31:0] domain_max;
    logic [10:0] member_count;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] operation = '0;
  logic signed [31:0] value_a = '0;
  logic signed [31:0] value_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic found;
  logic signed [31:0] answer_value;
  logic [1:0] answer_kind;
  logic signed [31:0] domain_min;
  logic signed [31:0] domain_max;
  logic [ids_pkg::CNT_W-1:0] member_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  integer_domain_bitset_store u_dut (.*);

  always #4 clk = ~clk;

  // shadow copy of the domain
  logic        shadow_bits [0:ids_pkg::DOMAIN_BITS-1];
  longint      shadow_lo_off, shadow_hi_off, shadow_pop;
  logic [31:0] shadow_low_reg, shadow_high_reg;

  answer_t pending_answers[$];
  int      errors = 0;
  int      idle_cycles = 0;
  int      out_hold = 0;
  bit      calm = 0;

  function automatic logic member_at(longint o);
    if (o < 0 || o >= ids_pkg::DOMAIN_BITS) return 1'b0;
    return shadow_bits[o];
  endfunction

  function automatic void load_full(longint span);
    if (span > ids_pkg::DOMAIN_BITS) span = ids_pkg::DOMAIN_BITS;
    if (span == 0) span = 1;
    for (int i = 0; i < ids_pkg::DOMAIN_BITS; i++) shadow_bits[i] = (i < span);
    shadow_lo_off = 0;
    shadow_hi_off = span - 1;
    shadow_pop = span;
  endfunction

  // work out the answer of one word and update the shadow domain
  function automatic answer_t predict_domain_op(logic [2:0] op, logic [31:0] a32,
                                                logic [31:0] b32);
    answer_t r;
    longint a, b, low, hi, minv, maxv, ans, o, v, ca, cb;
    logic [1:0] kind;
    logic fnd;
    logic [2:0] sts;
    a = longint'(signed'(a32));
    b = longint'(signed'(b32));
    low = longint'(signed'(shadow_low_reg));
    minv = low + shadow_lo_off;
    maxv = low + shadow_hi_off;
    sts = ids_pkg::STS_QUERY;
    fnd = 1'b0;
    kind = ids_pkg::KIND_FINITE;
    ans = 0;
    case (op)
      ids_pkg::OP_REMOVE: begin
        if (a > b) sts = ids_pkg::STS_INVALID;
        else if (a <= minv && maxv <= b) sts = ids_pkg::STS_CLEAR;
        else if (b < minv || maxv < a) sts = ids_pkg::STS_NOCHG;
        else begin
          ca = (a < minv) ? minv : a;
          cb = (b > maxv) ? maxv : b;
          for (o = ca - low; o <= cb - low; o++) begin
            if (member_at(o)) begin
              shadow_bits[o] = 1'b0;
              shadow_pop--;
            end
          end
          if (ca == minv) begin
            for (o = cb - low + 1; o <= shadow_hi_off; o++)
              if (member_at(o)) begin
                shadow_lo_off = o;
                break;
              end
          end else if (cb == maxv) begin
            for (o = ca - low - 1; o >= shadow_lo_off; o--)
              if (member_at(o)) begin
                shadow_hi_off = o;
                break;
              end
          end
          sts = ids_pkg::STS_CHANGED;
        end
      end
      ids_pkg::OP_CONTAINS: fnd = (a >= minv && a <= maxv && member_at(a - low));
      ids_pkg::OP_NEXT: begin
        if (a >= maxv) kind = ids_pkg::KIND_PINF;
        else if (a < minv) ans = minv;
        else begin
          kind = ids_pkg::KIND_PINF;
          for (o = a - low + 1; o <= shadow_hi_off; o++)
            if (member_at(o)) begin
              ans = low + o;
              kind = ids_pkg::KIND_FINITE;
              break;
            end
        end
      end
      ids_pkg::OP_PREV: begin
        if (a <= minv) kind = ids_pkg::KIND_MINF;
        else if (a > maxv) ans = maxv;
        else begin
          kind = ids_pkg::KIND_MINF;
          for (o = a - low - 1; o >= shadow_lo_off; o--)
            if (member_at(o)) begin
              ans = low + o;
              kind = ids_pkg::KIND_FINITE;
              break;
            end
        end
      end
      ids_pkg::OP_GAP: begin
        kind = ids_pkg::KIND_PINF;
        for (v = ((a < minv) ? minv : a) + 1; v <= maxv; v++)
          if (!member_at(v - low)) begin
            ans = v;
            kind = ids_pkg::KIND_FINITE;
            fnd = 1'b1;
            break;
          end
      end
      ids_pkg::OP_CRANGE: begin
        if (a > b) sts = ids_pkg::STS_INVALID;
        else if (a >= minv && b <= maxv) begin
          fnd = 1'b1;
          for (v = a; v <= b; v++)
            if (!member_at(v - low)) begin
              fnd = 1'b0;
              break;
            end
        end
      end
      ids_pkg::OP_RELOAD: begin
        hi = longint'(signed'(shadow_high_reg));
        if (low > hi || hi - low + 1 > ids_pkg::DOMAIN_BITS) sts = ids_pkg::STS_INVALID;
        else begin
          load_full(hi - low + 1);
          sts = ids_pkg::STS_CHANGED;
        end
      end
      default: sts = ids_pkg::STS_INVALID;
    endcase
    r.status = sts;
    r.found = fnd;
    r.answer_value = ans[31:0];
    r.answer_kind = kind;
    r.domain_min = 32'(low + shadow_lo_off);
    r.domain_max = 32'(low + shadow_hi_off);
    r.member_count = shadow_pop[10:0];
    return r;
  endfunction

  // send one word, keeping valid high when no gap is drawn
  task automatic send_word(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    int gap;
    answer_t exp_ans;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation <= op;
    value_a <= a;
    value_b <= b;
    in_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (in_valid && !in_stall) break;
    end
    exp_ans = predict_domain_op(op, a, b);
    pending_answers = {pending_answers, exp_ans};
    @(negedge clk);
  endtask

  // let the block drain before touching registers
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == REG_LOW) shadow_low_reg = data;
    else shadow_high_reg = data;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // value near the current domain, or anywhere now and then
  function automatic logic [31:0] near_value();
    longint base;
    base = longint'(signed'(shadow_low_reg));
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'(base + longint'($urandom_range(0, 1100)) - 40);
  endfunction

  task automatic send_random_word();
    logic [31:0] a, b;
    int pick;
    pick = $urandom_range(0, 99);
    a = near_value();
    b = 32'(longint'(signed'(a)) + $urandom_range(0, 30));
    if ($urandom_range(0, 19) == 0) b = near_value();
    if (pick < 25) send_word(ids_pkg::OP_REMOVE, a, b);
    else if (pick < 37) send_word(ids_pkg::OP_CONTAINS, a, b);
    else if (pick < 49) send_word(ids_pkg::OP_NEXT, a, b);
    else if (pick < 61) send_word(ids_pkg::OP_PREV, a, b);
    else if (pick < 73) send_word(ids_pkg::OP_GAP, a, b);
    else if (pick < 90) send_word(ids_pkg::OP_CRANGE, a, b);
    else if (pick < 95) send_word(ids_pkg::OP_RELOAD, a, b);
    else send_word(OP_UNUSED, a, b);
  endtask

  task automatic test_directed();
    send_word(ids_pkg::OP_CONTAINS, 0, 0);
    send_word(ids_pkg::OP_CONTAINS, 1023, 0);
    send_word(ids_pkg::OP_CONTAINS, -1, 0);
    send_word(ids_pkg::OP_NEXT, -5, 0);
    send_word(ids_pkg::OP_NEXT, 1023, 0);
    send_word(ids_pkg::OP_PREV, 0, 0);
    send_word(ids_pkg::OP_PREV, 2000, 0);
    send_word(ids_pkg::OP_GAP, 10, 0);
    send_word(ids_pkg::OP_REMOVE, 20, 10);
    send_word(ids_pkg::OP_REMOVE, 32'h8000_0000, 32'h7fff_ffff);
    send_word(ids_pkg::OP_REMOVE, 2000, 3000);
    send_word(ids_pkg::OP_REMOVE, -10, 9);
    send_word(ids_pkg::OP_REMOVE, 1000, 2000);
    send_word(ids_pkg::OP_REMOVE, 100, 199);
    send_word(ids_pkg::OP_GAP, 50, 0);
    send_word(ids_pkg::OP_NEXT, 99, 0);
    send_word(ids_pkg::OP_PREV, 200, 0);
    send_word(ids_pkg::OP_CRANGE, 100, 199);
    send_word(ids_pkg::OP_CRANGE, 10, 99);
    send_word(ids_pkg::OP_CRANGE, 32'h8000_0000, 32'h7fff_ffff);
    send_word(ids_pkg::OP_CRANGE, 50, 40);
    send_word(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    send_word(ids_pkg::OP_RELOAD, 0, 0);
  endtask

  // program one setting, reload it and run random words on it
  task automatic test_setting(logic [31:0] low, logic [31:0] high, int count);
    wait_drained();
    write_reg(REG_LOW, low);
    write_reg(REG_HIGH, high);
    calm = ($urandom_range(0, 3) == 0);
    send_word(ids_pkg::OP_RELOAD, 0, 0);
    repeat (count) send_random_word();
  endtask

  // shift every member by rewriting the base alone
  task automatic test_base_shift();
    wait_drained();
    write_reg(REG_LOW, -300);
    calm = 0;
    repeat (180) send_random_word();
  endtask

  // result checking
  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
    end
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (out_valid && !out_stall) begin
      out_hold = calm ? 0 : $urandom_range(0, 8);
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: result with no word outstanding, expected none, actual status %0d",
                 $time, status);
      end else begin
        e = pending_answers.pop_front();
        check_field("status", e.status, status);
        check_field("found", e.found, found);
        check_field("answer_value", e.answer_value, answer_value);
        check_field("answer_kind", e.answer_kind, answer_kind);
        check_field("domain_min", e.domain_min, domain_min);
        check_field("domain_max", e.domain_max, domain_max);
        check_field("member_count", e.member_count, member_count);
      end
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("integer_domain_bitset_store_test: done, errors");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    shadow_low_reg = 0;
    shadow_high_reg = 1023;
    load_full(1024);
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_setting(0, 1023, 190);
    test_setting(32'h8000_0000, 32'h8000_03ff, 190);
    test_setting(32'h7fff_fd78, 32'h7fff_ffff, 190);
    test_setting(-5, 57, 190);
    test_setting(100, 100, 150);
    test_setting(10, 5, 150);
    test_setting(0, 1024, 150);
    test_setting(32'hffff_ff00, 32'h0000_00ff, 150);
    test_base_shift();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
    if (errors == 0)
      $display("integer_domain_bitset_store_test: done, clean");
    else
      $display("integer_domain_bitset_store_test: done, errors");
    $finish;
  end

endmodule

// ----- integer_domain_bitset_store.f -----
design/ids_pkg.sv
design/ids_cell.sv
design/ids_head.sv
design/integer_domain_bitset_store.sv
test/integer_domain_bitset_store_test.sv
